/* rtl/setting_write_pacer_core_defines.svh */
// ----------------------------------------------------------------------------
// Setting write pacer assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SETTING_WRITE_PACER_CORE_DEFINES_SVH
`define SETTING_WRITE_PACER_CORE_DEFINES_SVH

`ifndef SYNTH
// implication checked every edge outside reset
`define SWP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// plain invariant checked every edge outside reset
`define SWP_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`else
`define SWP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SWP_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`endif

`endif

/* rtl/swp_pkg.sv */
// ----------------------------------------------------------------------------
// swp_pkg
// Shared types, codes and time helpers of the setting write pacer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swp_pkg;

    localparam int TIME_W = 32;
    localparam int MS_W   = 16;
    localparam int CFG_W  = 16;
    localparam int CIDX_W = 3;
    localparam int SIDX_W = 3;
    localparam int MASK_W = 8;
    localparam int LIM_W  = 3;

    typedef enum logic [1:0] {
        OP_POLL     = 2'd0,
        OP_TAP      = 2'd1,
        OP_READBACK = 2'd2,
        OP_LINK     = 2'd3
    } t_op;

    typedef enum logic [CIDX_W-1:0] {
        CFG_TOGGLE_MASK = 3'd0,
        CFG_DEBOUNCE    = 3'd1,
        CFG_WRITE_GAP   = 3'd2,
        CFG_RESEND_GAP  = 3'd3,
        CFG_ECHO_GRACE  = 3'd4,
        CFG_RESEND_LIM  = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RMW_RD,
        S_RMW,
        S_SCAN_RD,
        S_SCAN,
        S_SHOW_RD,
        S_SHOW,
        S_OUT
    } t_state;

    // true once now has reached t, modulo 2^32
    function automatic logic time_reached(input logic [TIME_W-1:0] now,
                                          input logic [TIME_W-1:0] t);
        logic [TIME_W-1:0] diff;
        diff = now - t;
        return ~diff[TIME_W-1];
    endfunction

endpackage

`default_nettype wire

/* rtl/swp_slot_ram.sv */
// ----------------------------------------------------------------------------
// swp_slot_ram
// Per-slot record store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swp_slot_ram #(
    parameter int DEPTH  = 8,
    parameter int DATA_W = 123,
    parameter int ADDR_W = 3
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/setting_write_pacer_core.sv */
// Sequence: a link edge or a skipped operation goes through SHOW_RD, SHOW and OUT,
//   a tap or readback first RMW_RD and RMW, a poll pass SCAN_RD and SCAN per slot until a
//   write is chosen or the last slot, set by the one read port of the slot record memory.
// Throughput: one transaction in flight; the next is taken the cycle after the result leaves.
// Reset: synchronous active low; clears control, slot flags, link state and
//   registers to their defaults. Slot records stay undefined until written.
// ----------------------------------------------------------------------------
// setting_write_pacer_core
// Paces writes of device settings; per-slot records live in a memory and are
// updated by read-modify-write, per-slot flags live in flip-flops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "setting_write_pacer_core_defines.svh"

module setting_write_pacer_core
    import swp_pkg::*;
#(
    parameter int SETTING_SLOTS = 8,
    parameter int VALUE_BITS    = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // config write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CIDX_W-1:0]     i_cfg_index,
    input  wire logic [CFG_W-1:0]      i_cfg_data,
    // input channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [1:0]            i_operation,
    input  wire logic [TIME_W-1:0]     i_time_now,
    input  wire logic [SIDX_W-1:0]     i_setting_index,
    input  wire logic [VALUE_BITS-1:0] i_option_value,
    input  wire logic                  i_link_is_up,
    // output channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_send_valid,
    output logic [SIDX_W-1:0]          o_send_index,
    output logic [VALUE_BITS-1:0]      o_send_value,
    output logic                       o_shown_valid,
    output logic [VALUE_BITS-1:0]      o_shown_value
);

    localparam int SLOT_W = (SETTING_SLOTS > 1) ? $clog2(SETTING_SLOTS) : 1;
    localparam int VB     = VALUE_BITS;

    // record layout in slot memory
    localparam int KV_LO = 0;                 // known value
    localparam int PV_LO = KV_LO + VB;        // posted value
    localparam int RV_LO = PV_LO + VB;        // resend value
    localparam int GD_LO = RV_LO + VB;        // grace deadline
    localparam int PS_LO = GD_LO + TIME_W;    // posted since
    localparam int RD_LO = PS_LO + TIME_W;    // resend due
    localparam int RR_LO = RD_LO + TIME_W;    // resends remaining
    localparam int REC_W = RR_LO + LIM_W;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SETTING_SLOTS - 1);

    // config registers
    logic [MASK_W-1:0] r_toggle_mask;
    logic [MS_W-1:0]   r_debounce_ms;
    logic [MS_W-1:0]   r_write_gap_ms;
    logic [MS_W-1:0]   r_resend_gap_ms;
    logic [MS_W-1:0]   r_echo_grace_ms;
    logic [LIM_W-1:0]  r_resend_limit;

    // control
    t_state r_state;
    t_state n_state;
    logic   r_link_up;
    logic [TIME_W-1:0] r_next_write;

    // per-slot flags
    logic [SETTING_SLOTS-1:0] r_known_valid;
    logic [SETTING_SLOTS-1:0] r_grace_active;
    logic [SETTING_SLOTS-1:0] r_posted_valid;
    logic [SETTING_SLOTS-1:0] r_resend_valid;

    // captured transaction
    t_op               r_op;
    logic [TIME_W-1:0] r_now;
    logic [SIDX_W-1:0] r_idx;
    logic [VB-1:0]     r_val;
    logic              r_in_range;
    logic [SLOT_W-1:0] r_scan;

    // result registers
    logic              r_out_valid;
    logic              r_send_valid;
    logic [SIDX_W-1:0] r_send_index;
    logic [VB-1:0]     r_send_value;
    logic              r_shown_valid;
    logic [VB-1:0]     r_shown_value;

    // memory port
    logic              w_we;
    logic [SLOT_W-1:0] w_waddr;
    logic [REC_W-1:0]  w_wdata;
    logic [SLOT_W-1:0] w_raddr;
    logic [REC_W-1:0]  w_rdata;

    // record fields of current read
    logic [VB-1:0]     w_kv, w_pv, w_rv;
    logic [TIME_W-1:0] w_gd, w_ps, w_rd;
    logic [LIM_W-1:0]  w_rr;

    logic [SLOT_W-1:0] w_idx_slot;
    logic              w_accept;
    logic              w_in_range;

    // flag updates for the slot being worked on
    logic w_set_known, w_set_grace, w_clr_grace, w_set_posted, w_clr_posted;
    logic w_set_resend, w_chosen;
    logic [SLOT_W-1:0] w_fslot;

    // readback decision helpers
    logic w_toggle, w_confirm;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_in_range = 32'(i_setting_index) < 32'(SETTING_SLOTS);
    assign w_idx_slot = SLOT_W'(r_idx);

    assign w_kv = w_rdata[KV_LO +: VB];
    assign w_pv = w_rdata[PV_LO +: VB];
    assign w_rv = w_rdata[RV_LO +: VB];
    assign w_gd = w_rdata[GD_LO +: TIME_W];
    assign w_ps = w_rdata[PS_LO +: TIME_W];
    assign w_rd = w_rdata[RD_LO +: TIME_W];
    assign w_rr = w_rdata[RR_LO +: LIM_W];

    swp_slot_ram #(
        .DEPTH  (SETTING_SLOTS),
        .DATA_W (REC_W),
        .ADDR_W (SLOT_W)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_toggle_mask   <= '0;
            r_debounce_ms   <= MS_W'(400);
            r_write_gap_ms  <= MS_W'(1200);
            r_resend_gap_ms <= MS_W'(1200);
            r_echo_grace_ms <= MS_W'(4000);
            r_resend_limit  <= LIM_W'(2);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TOGGLE_MASK: r_toggle_mask   <= i_cfg_data[MASK_W-1:0];
                CFG_DEBOUNCE:    r_debounce_ms   <= i_cfg_data;
                CFG_WRITE_GAP:   r_write_gap_ms  <= i_cfg_data;
                CFG_RESEND_GAP:  r_resend_gap_ms <= i_cfg_data;
                CFG_ECHO_GRACE:  r_echo_grace_ms <= i_cfg_data;
                CFG_RESEND_LIM:  r_resend_limit  <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (t_op'(i_operation))
                        OP_TAP:
                            n_state = (w_in_range && r_link_up) ? S_RMW_RD : S_SHOW_RD;
                        OP_READBACK:
                            n_state = w_in_range ? S_RMW_RD : S_SHOW_RD;
                        OP_POLL:
                            n_state = (r_link_up && time_reached(i_time_now, r_next_write))
                                      ? S_SCAN_RD : S_SHOW_RD;
                        OP_LINK:
                            n_state = S_SHOW_RD;
                        default: n_state = S_SHOW_RD;
                    endcase
                end
            end
            S_RMW_RD:  n_state = S_RMW;
            S_RMW:     n_state = S_SHOW_RD;
            S_SCAN_RD: n_state = S_SCAN;
            S_SCAN:    n_state = (w_chosen || r_scan == LAST_SLOT) ? S_SHOW_RD : S_SCAN_RD;
            S_SHOW_RD: n_state = S_SHOW;
            S_SHOW:    n_state = S_OUT;
            S_OUT:     n_state = i_out_stall ? S_OUT : S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // read address, write record and flag decisions
    always_comb begin
        w_raddr      = (r_state == S_SCAN_RD) ? r_scan : w_idx_slot;
        w_we         = 1'b0;
        w_waddr      = w_idx_slot;
        w_wdata      = w_rdata;
        w_fslot      = w_idx_slot;
        w_set_known  = 1'b0;
        w_set_grace  = 1'b0;
        w_clr_grace  = 1'b0;
        w_set_posted = 1'b0;
        w_clr_posted = 1'b0;
        w_set_resend = 1'b0;
        w_chosen     = 1'b0;
        w_toggle     = (32'(r_idx) < 32'(MASK_W)) && r_toggle_mask[r_idx];
        w_confirm    = r_known_valid[w_idx_slot] &&
                       (w_toggle ? ((r_val == '0) == (w_kv == '0)) : (r_val == w_kv));
        unique case (r_state)
            S_RMW: begin
                if (r_op == OP_TAP) begin
                    w_we = 1'b1;
                    w_wdata[KV_LO +: VB]     = r_val;
                    w_wdata[PV_LO +: VB]     = r_val;
                    w_wdata[PS_LO +: TIME_W] = r_now;
                    w_wdata[GD_LO +: TIME_W] = r_now + TIME_W'(r_echo_grace_ms);
                    w_set_known  = 1'b1;
                    w_set_grace  = 1'b1;
                    w_set_posted = 1'b1;
                end else if (!r_posted_valid[w_idx_slot]) begin
                    // readback; stale echo inside grace is dropped
                    w_wdata[KV_LO +: VB] = r_val;
                    if (!r_grace_active[w_idx_slot]) begin
                        w_we        = 1'b1;
                        w_set_known = 1'b1;
                    end else if (w_confirm) begin
                        w_we        = 1'b1;
                        w_clr_grace = 1'b1;
                    end else if (time_reached(r_now, w_gd)) begin
                        w_we        = 1'b1;
                        w_clr_grace = 1'b1;
                        w_set_known = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                w_waddr = r_scan;
                w_fslot = r_scan;
                w_wdata[RD_LO +: TIME_W] = r_now + TIME_W'(r_resend_gap_ms);
                w_wdata[GD_LO +: TIME_W] = r_now + TIME_W'(r_echo_grace_ms);
                if (r_posted_valid[r_scan]) begin
                    if (time_reached(r_now, w_ps + TIME_W'(r_debounce_ms))) begin
                        w_chosen     = 1'b1;
                        w_we         = 1'b1;
                        w_wdata[RV_LO +: VB]    = w_pv;
                        w_wdata[RR_LO +: LIM_W] = r_resend_limit;
                        w_clr_posted = 1'b1;
                        w_set_resend = 1'b1;
                        w_set_grace  = 1'b1;
                    end
                end else if (r_resend_valid[r_scan] && w_rr != '0 &&
                             time_reached(r_now, w_rd)) begin
                    w_chosen    = 1'b1;
                    w_we        = 1'b1;
                    w_wdata[RR_LO +: LIM_W] = w_rr - LIM_W'(1);
                    w_set_grace = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // control, flags and results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_link_up      <= 1'b0;
            r_next_write   <= '0;
            r_known_valid  <= '0;
            r_grace_active <= '0;
            r_posted_valid <= '0;
            r_resend_valid <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept && t_op'(i_operation) == OP_LINK) begin
                r_link_up      <= i_link_is_up;
                r_known_valid  <= '0;
                r_grace_active <= '0;
                r_posted_valid <= '0;
                r_resend_valid <= '0;
            end else if (w_accept && t_op'(i_operation) == OP_POLL && r_link_up) begin
                // unconfirmed-write tracking ends once grace is over
                r_resend_valid <= r_resend_valid & r_grace_active;
            end else begin
                if (w_set_known)  r_known_valid[w_fslot]  <= 1'b1;
                if (w_set_grace)  r_grace_active[w_fslot] <= 1'b1;
                if (w_clr_grace)  r_grace_active[w_fslot] <= 1'b0;
                if (w_set_posted) r_posted_valid[w_fslot] <= 1'b1;
                if (w_clr_posted) r_posted_valid[w_fslot] <= 1'b0;
                if (w_set_resend) r_resend_valid[w_fslot] <= 1'b1;
            end
            if (w_chosen) begin
                r_next_write <= r_now + TIME_W'(r_write_gap_ms);
            end
            if (r_state == S_SHOW) begin
                r_out_valid <= 1'b1;
            end else if (r_state == S_OUT && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op         <= t_op'(i_operation);
            r_now        <= i_time_now;
            r_idx        <= i_setting_index;
            r_val        <= i_option_value;
            r_in_range   <= w_in_range;
            r_scan       <= '0;
            r_send_valid <= 1'b0;
            r_send_index <= '0;
            r_send_value <= '0;
        end else if (r_state == S_SCAN) begin
            r_scan <= r_scan + SLOT_W'(1);
            if (w_chosen) begin
                r_send_valid <= 1'b1;
                r_send_index <= SIDX_W'(r_scan);
                r_send_value <= r_posted_valid[r_scan] ? w_pv : w_rv;
            end
        end
        if (r_state == S_SHOW) begin
            if (r_in_range && r_posted_valid[w_idx_slot]) begin
                r_shown_valid <= 1'b1;
                r_shown_value <= w_pv;
            end else if (r_in_range && r_known_valid[w_idx_slot]) begin
                r_shown_valid <= 1'b1;
                r_shown_value <= w_kv;
            end else begin
                r_shown_valid <= 1'b0;
                r_shown_value <= '0;
            end
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_send_valid  = r_send_valid;
    assign o_send_index  = r_send_index;
    assign o_send_value  = r_send_value;
    assign o_shown_valid = r_shown_valid;
    assign o_shown_value = r_shown_value;

    // a posted slot always has its optimistic known value set
    `SWP_ASSERT_ALWAYS(a_posted_known, i_clk, i_rst_n, (r_posted_valid & ~r_known_valid) == '0, "posted slot without known value")
    // slot records are written only during update or scan
    `SWP_ASSERT_IMP(a_we_state, i_clk, i_rst_n, w_we, (r_state == S_RMW || r_state == S_SCAN), "record write outside update")
    // a write is only chosen while the link is up
    `SWP_ASSERT_IMP(a_send_link, i_clk, i_rst_n, r_out_valid && r_send_valid, r_link_up, "send chosen with link down")
    // result register pairs with the output state
    `SWP_ASSERT_IMP(a_out_state, i_clk, i_rst_n, r_out_valid, r_state == S_OUT, "result valid outside output state")

endmodule

`default_nettype wire

/* verif/tb_setting_write_pacer_core.sv */
// ----------------------------------------------------------------------------
// tb_setting_write_pacer_core
// Self-checking bench for the setting write pacer: a directed table, then
// random tap/poll/readback sessions, every result checked against a
// behavioral predictor, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_setting_write_pacer_core;
    import swp_pkg::*;

    localparam int SLOTS      = 8;
    localparam int CYCLE_CAP  = 1500000;
    localparam int DRAIN_WAIT = 64;

    // one input transaction
    typedef struct {
        t_op         op;
        logic [31:0] now;
        logic [2:0]  idx;
        logic [7:0]  val;
        logic        up;
    } t_item;

    // one result transaction
    typedef struct {
        logic       snd_v;
        logic [2:0] snd_i;
        logic [7:0] snd_val;
        logic       shw_v;
        logic [7:0] shw_val;
    } t_res;

    // directed row; chk means the typed-in result is compared too
    typedef struct {
        t_item it;
        logic  chk;
        t_res  res;
    } t_row;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  operation = '0;
    logic [31:0] time_now = '0;
    logic [2:0]  setting_index = '0;
    logic [7:0]  option_value = '0;
    logic        link_is_up = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        send_valid;
    logic [2:0]  send_index;
    logic [7:0]  send_value;
    logic        shown_valid;
    logic [7:0]  shown_value;

    setting_write_pacer_core i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_operation    (operation),
        .i_time_now     (time_now),
        .i_setting_index(setting_index),
        .i_option_value (option_value),
        .i_link_is_up   (link_is_up),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_send_valid   (send_valid),
        .o_send_index   (send_index),
        .o_send_value   (send_value),
        .o_shown_valid  (shown_valid),
        .o_shown_value  (shown_value)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // ---------------- predictor state ----------------
    logic [7:0]  m_toggle;
    logic [15:0] m_debounce, m_wgap, m_rgap, m_grace;
    logic [2:0]  m_rlim;
    logic        p_link;
    logic [31:0] p_next_wr;
    logic        p_kv  [SLOTS];
    logic [7:0]  p_kval[SLOTS];
    logic        p_ga  [SLOTS];
    logic [31:0] p_gdl [SLOTS];
    logic        p_pv  [SLOTS];
    logic [7:0]  p_pval[SLOTS];
    logic [31:0] p_psin[SLOTS];
    logic        p_rv  [SLOTS];
    logic [7:0]  p_rval[SLOTS];
    logic [2:0]  p_rrem[SLOTS];
    logic [31:0] p_rdue[SLOTS];

    t_res        pending_results[$];
    int          fail_cnt = 0;
    int          cycles = 0;
    logic [31:0] clock_ms = 32'd1000;  // running millisecond time for stimulus

    function automatic logic is_reached(logic [31:0] now, logic [31:0] t);
        logic [31:0] d;
        d = now - t;
        return ~d[31];
    endfunction

    function automatic logic same_res(t_res a, t_res b);
        return a.snd_v === b.snd_v && a.snd_i === b.snd_i && a.snd_val === b.snd_val &&
               a.shw_v === b.shw_v && a.shw_val === b.shw_val;
    endfunction

    function automatic void wipe_slots();
        for (int i = 0; i < SLOTS; i++) begin
            p_kv[i] = 0; p_kval[i] = 0; p_ga[i] = 0; p_gdl[i] = 0;
            p_pv[i] = 0; p_pval[i] = 0; p_psin[i] = 0;
            p_rv[i] = 0; p_rval[i] = 0; p_rrem[i] = 0; p_rdue[i] = 0;
        end
    endfunction

    function automatic void regs_to_defaults();
        m_toggle = 8'd0; m_debounce = 16'd400; m_wgap = 16'd1200;
        m_rgap = 16'd1200; m_grace = 16'd4000; m_rlim = 3'd2;
        p_link = 0; p_next_wr = 0;
        wipe_slots();
    endfunction

    // poll pass: retire resends out of grace, then pick at most one write
    function automatic void pace_poll(logic [31:0] now, ref t_res r);
        int pick;
        logic [7:0] v;
        pick = -1;
        v = 0;
        if (!p_link) return;
        for (int i = 0; i < SLOTS; i++)
            if (p_rv[i] && !p_ga[i]) p_rv[i] = 0;
        if (!is_reached(now, p_next_wr)) return;
        for (int i = 0; i < SLOTS && pick < 0; i++) begin
            if (p_pv[i]) begin
                if (!is_reached(now, p_psin[i] + 32'(m_debounce))) continue;
                p_pv[i] = 0; pick = i; v = p_pval[i];
                p_rv[i] = 1; p_rval[i] = v; p_rrem[i] = m_rlim;
                p_rdue[i] = now + 32'(m_rgap);
                p_ga[i] = 1; p_gdl[i] = now + 32'(m_grace);
            end else if (p_rv[i] && p_rrem[i] != 0 && is_reached(now, p_rdue[i])) begin
                pick = i; v = p_rval[i];
                p_rrem[i] = p_rrem[i] - 1;
                p_rdue[i] = now + 32'(m_rgap);
                p_ga[i] = 1; p_gdl[i] = now + 32'(m_grace);
            end
        end
        if (pick >= 0) begin
            p_next_wr = now + 32'(m_wgap);
            r.snd_v = 1; r.snd_i = 3'(pick); r.snd_val = v;
        end
    endfunction

    function automatic void take_readback(logic [31:0] now, int s, logic [7:0] v);
        logic ok;
        if (p_pv[s]) return;
        if (p_ga[s]) begin
            if (!p_kv[s]) ok = 0;
            else if (m_toggle[s]) ok = ((v == 0) == (p_kval[s] == 0));
            else ok = (v == p_kval[s]);
            if (ok) begin
                p_ga[s] = 0; p_kval[s] = v;
                return;
            end
            if (!is_reached(now, p_gdl[s])) return;
            p_ga[s] = 0;
        end
        p_kval[s] = v; p_kv[s] = 1;
    endfunction

    function automatic t_res pace_step(t_item it);
        t_res r;
        int s;
        r = '{default: '0};
        s = int'(it.idx);
        case (it.op)
            OP_POLL: pace_poll(it.now, r);
            OP_TAP: if (p_link) begin
                p_kval[s] = it.val; p_kv[s] = 1; p_ga[s] = 1;
                p_gdl[s] = it.now + 32'(m_grace);
                p_psin[s] = it.now; p_pval[s] = it.val; p_pv[s] = 1;
            end
            OP_READBACK: take_readback(it.now, s, it.val);
            default: begin
                p_link = it.up;
                wipe_slots();
            end
        endcase
        if (p_pv[s]) begin
            r.shw_v = 1; r.shw_val = p_pval[s];
        end else if (p_kv[s]) begin
            r.shw_v = 1; r.shw_val = p_kval[s];
        end
        return r;
    endfunction

    // ---------------- channel handling ----------------
    // valid stays up across back-to-back transactions; it drops only on a gap or a drain
    task automatic send_item(t_item it, logic chk, t_res typed);
        t_res r;
        int gap;
        r = pace_step(it);
        if (chk && !same_res(r, typed)) begin
            $display("%0t table mismatch: expected %p actual %p", $time, typed, r);
            fail_cnt++;
        end
        gap = (($urandom & 3) == 0) ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pending_results.insert(pending_results.size(), r);
        in_valid      <= 1'b1;
        operation     <= it.op;
        time_now      <= it.now;
        setting_index <= it.idx;
        option_value  <= it.val;
        link_is_up    <= it.up;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] d);
        @(negedge clk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= d;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_TOGGLE_MASK: m_toggle   = d[7:0];
            CFG_DEBOUNCE:    m_debounce = d;
            CFG_WRITE_GAP:   m_wgap     = d;
            CFG_RESEND_GAP:  m_rgap     = d;
            CFG_ECHO_GRACE:  m_grace    = d;
            default:         m_rlim     = d[2:0];
        endcase
    endtask

    // receiver: random stall per transaction, compare at the rising edge
    logic stall_on = 1'b1;
    initial begin
        int hold;
        forever begin
            @(negedge clk);
            if (stall_on) begin
                hold = $urandom_range(0, 15);
                if (hold > 0) begin
                    out_stall <= 1'b1;
                    repeat (hold) @(negedge clk);
                end
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    always @(posedge clk) begin
        t_res got, want;
        if (rst_n && out_valid && !out_stall) begin
            got = '{send_valid, send_index, send_value, shown_valid, shown_value};
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result: expected none actual %p", $time, got);
                fail_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (!same_res(got, want)) begin
                    $display("%0t mismatch: expected %p actual %p", $time, want, got);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("** setting_write_pacer_core: FAILED **");
            $finish;
        end
    end

    function automatic t_item mk(t_op op, logic [31:0] now, logic [2:0] idx,
                                 logic [7:0] val, logic up);
        t_item it;
        it.op = op; it.now = now; it.idx = idx; it.val = val; it.up = up;
        return it;
    endfunction

    // random item biased toward tap/poll/readback sessions on a running clock
    function automatic t_item rand_item(logic [2:0] hot);
        t_item it;
        int k;
        k = $urandom_range(0, 99);
        clock_ms = clock_ms + 32'($urandom_range(0, 700));
        if (($urandom & 63) == 0) clock_ms = $urandom;  // occasional time jump
        it.now = clock_ms;
        it.idx = ($urandom_range(0, 3) == 0) ? 3'($urandom) : hot;
        it.val = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 1) * 255)
                                               : 8'($urandom);
        it.up  = ($urandom_range(0, 9) != 0);
        if (k < 45)      it.op = OP_POLL;
        else if (k < 70) it.op = OP_TAP;
        else if (k < 97) it.op = OP_READBACK;
        else             it.op = OP_LINK;
        return it;
    endfunction

    t_row dir_table[$];
    t_res none_res;

    function automatic void add_row(t_item it, logic chk, t_res res);
        t_row row;
        row.it = it; row.chk = chk; row.res = res;
        dir_table.insert(dir_table.size(), row);
    endfunction

    initial begin
        t_item it;
        logic [2:0] hot;
        none_res = '{default: '0};
        regs_to_defaults();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table; typed results where they are obvious
        add_row(mk(OP_POLL, 32'd0, 3'd0, 8'd0, 1'b0), 1, none_res);
        add_row(mk(OP_TAP, 32'd5, 3'd7, 8'hFF, 1'b0), 1, none_res);
        add_row(mk(OP_LINK, 32'd10, 3'd0, 8'd0, 1'b1), 1, none_res);
        add_row(mk(OP_TAP, 32'd100, 3'd7, 8'hFF, 1'b0), 1,
                '{1'b0, 3'd0, 8'd0, 1'b1, 8'hFF});
        add_row(mk(OP_TAP, 32'd120, 3'd0, 8'h00, 1'b0), 0, none_res);
        add_row(mk(OP_POLL, 32'd200, 3'd0, 8'd0, 1'b0), 0, none_res);
        add_row(mk(OP_READBACK, 32'd300, 3'd7, 8'h11, 1'b0), 0, none_res);
        add_row(mk(OP_POLL, 32'd600, 3'd7, 8'd0, 1'b0), 0, none_res);
        add_row(mk(OP_POLL, 32'd1900, 3'd0, 8'd0, 1'b0), 0, none_res);
        add_row(mk(OP_READBACK, 32'd2000, 3'd7, 8'h22, 1'b0), 0, none_res);
        add_row(mk(OP_READBACK, 32'd9000, 3'd7, 8'h33, 1'b0), 0, none_res);
        add_row(mk(OP_READBACK, 32'd9100, 3'd5, 8'hA5, 1'b0), 0, none_res);
        add_row(mk(OP_POLL, 32'd3100, 3'd0, 8'd0, 1'b0), 0, none_res);
        add_row(mk(OP_POLL, 32'd4400, 3'd0, 8'd0, 1'b0), 0, none_res);
        add_row(mk(OP_POLL, 32'd5700, 3'd0, 8'd0, 1'b0), 0, none_res);
        // time wrap: tap near the top of the clock, poll after wrap
        add_row(mk(OP_TAP, 32'hFFFF_FF00, 3'd3, 8'h5A, 1'b0), 0, none_res);
        add_row(mk(OP_POLL, 32'h0000_0400, 3'd3, 8'd0, 1'b0), 0, none_res);
        // repeated edge at the same level still clears
        add_row(mk(OP_LINK, 32'h0000_0500, 3'd3, 8'd0, 1'b1), 1, none_res);
        add_row(mk(OP_LINK, 32'h0000_0600, 3'd2, 8'd0, 1'b0), 1, none_res);
        add_row(mk(OP_POLL, 32'h0000_0700, 3'd2, 8'd0, 1'b0), 1, none_res);
        add_row(mk(OP_READBACK, 32'h0000_0800, 3'd4, 8'h80, 1'b0), 1,
                '{1'b0, 3'd0, 8'd0, 1'b1, 8'h80});
        foreach (dir_table[r]) send_item(dir_table[r].it, dir_table[r].chk, dir_table[r].res);
        // hold off until every result is back
        wait_drained();

        stall_on = 1'b1;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_TOGGLE_MASK, 16'h00FF); write_reg(CFG_DEBOUNCE, 16'd0);
                    write_reg(CFG_WRITE_GAP, 16'd0);      write_reg(CFG_RESEND_GAP, 16'd0);
                    write_reg(CFG_ECHO_GRACE, 16'd0);     write_reg(CFG_RESEND_LIM, 16'd7);
                end
                1: begin
                    write_reg(CFG_TOGGLE_MASK, 16'h00A5); write_reg(CFG_DEBOUNCE, 16'hFFFF);
                    write_reg(CFG_WRITE_GAP, 16'hFFFF);   write_reg(CFG_RESEND_GAP, 16'hFFFF);
                    write_reg(CFG_ECHO_GRACE, 16'hFFFF);  write_reg(CFG_RESEND_LIM, 16'd0);
                end
                default: begin
                    write_reg(CFG_TOGGLE_MASK, 16'($urandom));
                    write_reg(CFG_DEBOUNCE, 16'($urandom_range(0, 1500)));
                    write_reg(CFG_WRITE_GAP, 16'($urandom_range(0, 2500)));
                    write_reg(CFG_RESEND_GAP, 16'($urandom_range(0, 2500)));
                    write_reg(CFG_ECHO_GRACE, 16'($urandom_range(0, 6000)));
                    write_reg(CFG_RESEND_LIM, 16'($urandom_range(0, 7)));
                end
            endcase
            // session opens with link up so taps get through
            send_item(mk(OP_LINK, clock_ms, 3'd0, 8'd0, 1'b1), 0, none_res);
            hot = 3'($urandom);
            for (int n = 0; n < 155; n++) begin
                if (($urandom & 15) == 0) hot = 3'($urandom);
                it = rand_item(hot);
                send_item(it, 0, none_res);
            end
            wait_drained();
        end

        if (fail_cnt == 0) begin
            $display("** setting_write_pacer_core: PASSED **");
        end else begin
            $display("** setting_write_pacer_core: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
